// ===== sv/lin_master_frame_engine_defines.svh =====
// ----------------------------------------------------------------------------
// LIN master frame engine assertion macros
// Shared concurrent assertion forms; every use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LIN_MASTER_FRAME_ENGINE_DEFINES_SVH
`define LIN_MASTER_FRAME_ENGINE_DEFINES_SVH

// consequent checked in the same cycle
`define LMFE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define LMFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lmfe_pkg.sv =====
// ----------------------------------------------------------------------------
// LIN master frame engine package
// Shared constants, codes, payload structs and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package lmfe_pkg;

  localparam int MAX_DATA_BYTES = 8;
  localparam int STORE_DEPTH    = MAX_DATA_BYTES + 3;
  localparam int IDX_W          = $clog2(STORE_DEPTH);
  localparam int CNT_W          = $clog2(STORE_DEPTH + 1);
  localparam int LEN_W          = 4;

  localparam logic [7:0] SYNC_BYTE = 8'h55;

  localparam logic [1:0] REQ_SEND     = 2'd0;
  localparam logic [1:0] REQ_TX_EMPTY = 2'd1;
  localparam logic [1:0] REQ_RX_BYTE  = 2'd2;

  localparam logic [2:0] EV_ACCEPTED = 3'd0;
  localparam logic [2:0] EV_REJECTED = 3'd1;
  localparam logic [2:0] EV_BYTE_OUT = 3'd2;
  localparam logic [2:0] EV_TX_DONE  = 3'd3;
  localparam logic [2:0] EV_STORED   = 3'd4;
  localparam logic [2:0] EV_FRAME    = 3'd5;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [7:0]       pid;
    logic [LEN_W-1:0] data_len;
    logic [63:0]      frame_data;
    logic             checksum_enhanced;
    logic             send_data;
    logic [7:0]       rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic        break_request;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_pid;
    logic [63:0] rx_data;
    logic        busy_res;
  } out_item_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_CSUM
  } state_t;

  typedef struct packed {
    logic take;
    logic step;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic starts_sum;
    logic sum_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/lin_master_frame_engine.sv =====
// ----------------------------------------------------------------------------
// LIN master frame engine
// One LIN master channel: frame build, byte hand-out and frame receive.
// ----------------------------------------------------------------------------
// Usage:
//   in_item carries one request: send, transmitter empty or received byte.
//   A transaction is taken when in_valid is high and in_stall is low.
//   Each request gives exactly one out_item transaction on out_valid/out_stall.
//   Results: each result is registered and appears in the cycle after its request,
//   except an accepted send with data, which first runs the checksum one byte
//   per cycle and shows its result once the checksum is done and the result
//   slot is free (data_len capped at 8).
//   Throughput: one request per cycle, except an accepted send with data, which
//   keeps in_stall high until its checksum is done and its result is loaded.
//   A pending result holds while out_stall is high; a new request is taken
//   in the same cycle that the pending result leaves.
//   Reset (rst_n low, synchronous): channel idle, no result pending,
//   transmit and receive counters cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module lin_master_frame_engine
  import lmfe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  lmfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lmfe_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// ===== sv/lmfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// LIN master frame engine controller
// Handshake control, checksum sequencing and output valid tracking.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lin_master_frame_engine_defines.svh"

module lmfe_ctrl
  import lmfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire dp_status_t status,
  output ctl_cmd_t        cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    slot_free     = !out_valid_r || !out_stall;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = !slot_free;
        cmd.take = in_valid && slot_free;
        if (cmd.take) begin
          if (status.starts_sum) begin
            state_nxt = ST_CSUM;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_CSUM: begin
        if (!status.sum_done) begin
          cmd.step = 1'b1;
        end else if (slot_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `LMFE_ASSERT_NEXT(a_sum_enters_csum, cmd.take && status.starts_sum, state_r == ST_CSUM, "checksum send did not enter summing")
  `LMFE_ASSERT_NEXT(a_finish_loads, cmd.finish, out_valid_r, "finished send left no result")

endmodule

`default_nettype wire

// ===== sv/lmfe_datapath.sv =====
// ----------------------------------------------------------------------------
// LIN master frame engine datapath
// Transmit and receive stores, byte-serial checksum and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lin_master_frame_engine_defines.svh"

module lmfe_datapath
  import lmfe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_item,
  input  wire ctl_cmd_t  cmd,
  output dp_status_t     status,
  output out_item_t      out_item
);

  logic [7:0]       tx_store_r [STORE_DEPTH];
  logic [7:0]       rx_store_r [STORE_DEPTH];
  logic             busy_r;
  logic [CNT_W-1:0] tx_remaining_r;
  logic [CNT_W-1:0] tx_pos_r;
  logic [CNT_W-1:0] rx_count_r;
  logic [63:0]      data_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] cnt_r;
  logic [7:0]       sum_r;
  out_item_t        out_item_r;

  logic [LEN_W-1:0] len_sat;
  logic             send_ok;
  logic             tx_has_byte;
  logic             rx_has_room;
  logic [7:0]       sum_byte;
  logic [8:0]       sum_wide;
  logic [7:0]       sum_nxt;
  out_item_t        res;
  out_item_t        acc_res;

  always_comb begin
    len_sat = (in_item.data_len > LEN_W'(MAX_DATA_BYTES)) ?
              LEN_W'(MAX_DATA_BYTES) : in_item.data_len;
    send_ok     = (in_item.req_type == REQ_SEND) && !busy_r;
    tx_has_byte = (tx_remaining_r != '0) && (tx_pos_r < CNT_W'(STORE_DEPTH));
    rx_has_room = rx_count_r < CNT_W'(STORE_DEPTH);
    status.starts_sum = send_ok && in_item.send_data && (len_sat != '0);
    status.sum_done   = cnt_r == len_r;

    sum_byte = data_r[{cnt_r[2:0], 3'b000} +: 8];
    sum_wide = {1'b0, sum_r} + {1'b0, sum_byte};
    sum_nxt  = (sum_wide > 9'd255) ? 8'(sum_wide - 9'd255) : sum_wide[7:0];

    acc_res               = '0;
    acc_res.event_kind    = EV_ACCEPTED;
    acc_res.break_request = 1'b1;
    acc_res.busy_res      = 1'b1;

    res            = '0;
    res.event_kind = EV_REJECTED;
    res.busy_res   = busy_r;
    case (in_item.req_type)
      REQ_SEND: begin
        if (!busy_r) begin
          res = acc_res;
        end
      end
      REQ_TX_EMPTY: begin
        if (tx_has_byte) begin
          res.event_kind = EV_BYTE_OUT;
          res.tx_byte    = tx_store_r[tx_pos_r[IDX_W-1:0]];
        end else begin
          res.event_kind = EV_TX_DONE;
          res.busy_res   = 1'b0;
        end
      end
      REQ_RX_BYTE: begin
        if (rx_has_room) begin
          res.event_kind = EV_STORED;
        end else begin
          res.event_kind = EV_FRAME;
          res.rx_pid     = rx_store_r[2];
          for (int k = 0; k < MAX_DATA_BYTES; k++) begin
            res.rx_data[8*k +: 8] = rx_store_r[3+k];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b0;
      tx_remaining_r <= '0;
      tx_pos_r       <= '0;
      rx_count_r     <= '0;
    end else if (cmd.take) begin
      case (in_item.req_type)
        REQ_SEND: begin
          if (!busy_r) begin
            busy_r         <= 1'b1;
            tx_pos_r       <= '0;
            rx_count_r     <= '0;
            tx_remaining_r <= status.starts_sum ?
                              CNT_W'(len_sat) + CNT_W'(3) : CNT_W'(2);
          end
        end
        REQ_TX_EMPTY: begin
          if (tx_has_byte) begin
            tx_remaining_r <= tx_remaining_r - CNT_W'(1);
            tx_pos_r       <= tx_pos_r + CNT_W'(1);
          end else begin
            tx_remaining_r <= '0;
            busy_r         <= 1'b0;
          end
        end
        REQ_RX_BYTE: begin
          if (rx_has_room) begin
            rx_count_r <= rx_count_r + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && send_ok) begin
      tx_store_r[0] <= SYNC_BYTE;
      tx_store_r[1] <= in_item.pid;
      for (int k = 0; k < MAX_DATA_BYTES; k++) begin
        if (LEN_W'(k) < len_sat) begin
          tx_store_r[2+k] <= in_item.frame_data[8*k +: 8];
        end
      end
      data_r <= in_item.frame_data;
      len_r  <= len_sat;
      cnt_r  <= '0;
      sum_r  <= in_item.checksum_enhanced ? in_item.pid : 8'h00;
    end else if (cmd.step) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_r + LEN_W'(1);
    end else if (cmd.finish) begin
      tx_store_r[IDX_W'(len_r) + IDX_W'(2)] <= ~sum_r;
    end
    if (cmd.take && (in_item.req_type == REQ_RX_BYTE) && rx_has_room) begin
      rx_store_r[rx_count_r[IDX_W-1:0]] <= in_item.rx_byte;
    end
    if (cmd.take && !status.starts_sum) begin
      out_item_r <= res;
    end else if (cmd.finish) begin
      out_item_r <= acc_res;
    end
  end

  assign out_item = out_item_r;

  `LMFE_ASSERT_NEXT(a_send_sets_busy, cmd.take && (in_item.req_type == REQ_SEND), busy_r, "send left the channel idle")
  `LMFE_ASSERT_SAME(a_rx_count_range, 1'b1, rx_count_r <= CNT_W'(STORE_DEPTH), "receive count past store depth")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// LIN master frame engine testbench
// Drives send, transmitter-empty and receive transactions through the
// valid/stall handshake and checks every result against a cycle-free predictor
// of the channel (frame build, checksum, byte hand-out, frame receive) or a pinned event.
// A short scripted sequence covers the edge cases, then random frame
// exchanges and noise run under four phases of input idling and output stalling.
// ----------------------------------------------------------------------------
module tb;
  import lmfe_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN   = 2'd3;
  localparam int         QUIET_LIMIT   = 5000;
  localparam int         TAIL_CYCLES   = 20;
  localparam int         PHASE_ITEMS   = 175;
  localparam int         REPORT_LIMIT  = 10;

  typedef struct {
    in_item_t  req;
    int        reps;
    bit        pinned;
    out_item_t ev;
  } lin_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  bit        pin_valid = 1'b0;
  out_item_t pin_event = '0;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int sends_taken = 0;
  int bytes_out = 0;
  int frames_seen = 0;

  logic        chan_busy = 1'b0;
  logic [7:0]  tx_frame [STORE_DEPTH];
  int unsigned tx_left = 0;
  int unsigned tx_idx = 0;
  logic [7:0]  rx_frame [STORE_DEPTH];
  int unsigned rx_fill = 0;

  out_item_t lin_events_due [$];
  lin_row_t  lin_script [$];

  lin_master_frame_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic out_item_t predict_lin_event(in_item_t req);
    out_item_t   ev;
    int unsigned n;
    int unsigned sum;
    ev = '0;
    ev.event_kind = EV_REJECTED;
    n = (req.data_len > MAX_DATA_BYTES) ? MAX_DATA_BYTES : req.data_len;
    case (req.req_type)
      REQ_SEND: begin
        if (!chan_busy) begin
          tx_frame[0] = SYNC_BYTE;
          tx_frame[1] = req.pid;
          tx_idx = 0;
          if (n > 0 && req.send_data) begin
            sum = req.checksum_enhanced ? req.pid : 0;
            for (int k = 0; k < n; k++) begin
              tx_frame[2 + k] = req.frame_data[8 * k +: 8];
              sum += req.frame_data[8 * k +: 8];
              if (sum > 255) sum -= 255;
            end
            tx_frame[2 + n] = 8'hFF - sum[7:0];
            tx_left = n + 3;
          end else begin
            tx_left = 2;
          end
          foreach (rx_frame[i]) rx_frame[i] = 8'h00;
          rx_fill = 0;
          chan_busy = 1'b1;
          ev.event_kind = EV_ACCEPTED;
          ev.break_request = 1'b1;
        end
      end
      REQ_TX_EMPTY: begin
        if (tx_left > 0 && tx_idx < STORE_DEPTH) begin
          ev.tx_byte = tx_frame[tx_idx];
          tx_left--;
          tx_idx++;
          ev.event_kind = EV_BYTE_OUT;
        end else begin
          tx_left = 0;
          chan_busy = 1'b0;
          ev.event_kind = EV_TX_DONE;
        end
      end
      REQ_RX_BYTE: begin
        if (rx_fill < STORE_DEPTH) begin
          rx_frame[rx_fill] = req.rx_byte;
          rx_fill++;
          ev.event_kind = EV_STORED;
        end else begin
          ev.rx_pid = rx_frame[2];
          for (int k = 0; k < MAX_DATA_BYTES; k++)
            ev.rx_data[8 * k +: 8] = rx_frame[3 + k];
          ev.event_kind = EV_FRAME;
        end
      end
      default: ;
    endcase
    ev.busy_res = chan_busy;
    return ev;
  endfunction

  function automatic lin_row_t lin_row(logic [1:0] req, logic [7:0] pid, logic [3:0] len,
                                       logic [63:0] data, logic enh, logic sd,
                                       logic [7:0] rxb, int reps, bit pinned,
                                       logic [2:0] kind, logic brk, logic [7:0] txb,
                                       logic busy);
    lin_row_t r;
    r.req = '0;
    r.req.req_type = req;
    r.req.pid = pid;
    r.req.data_len = len;
    r.req.frame_data = data;
    r.req.checksum_enhanced = enh;
    r.req.send_data = sd;
    r.req.rx_byte = rxb;
    r.reps = reps;
    r.pinned = pinned;
    r.ev = '0;
    r.ev.event_kind = kind;
    r.ev.break_request = brk;
    r.ev.tx_byte = txb;
    r.ev.busy_res = busy;
    return r;
  endfunction

  function automatic in_item_t random_req();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  task automatic drive_request(in_item_t it, bit pinned, out_item_t ev);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_item   <= it;
    pin_valid <= pinned;
    pin_event <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.req_type != REQ_UNKNOWN) items_sent++;
    @(negedge clk);
  endtask

  task automatic run_frame_exchange();
    in_item_t it;
    int       frame_len;
    int       n_tx;
    int       n_rx;
    it = random_req();
    it.req_type = REQ_SEND;
    it.data_len = ($urandom_range(99) < 85) ? LEN_W'($urandom_range(8)) :
                                              LEN_W'($urandom_range(15, 9));
    it.send_data = ($urandom_range(99) < 85);
    if (it.send_data && it.data_len != 0)
      frame_len = ((it.data_len > MAX_DATA_BYTES) ? MAX_DATA_BYTES : it.data_len) + 3;
    else
      frame_len = 2;
    drive_request(it, 1'b0, '0);
    n_tx = frame_len + 1;
    if ($urandom_range(99) < 10) n_tx = $urandom_range(frame_len + 3);
    n_rx = ($urandom_range(99) < 70) ? $urandom_range(15, 11) : $urandom_range(10);
    while (n_tx + n_rx > 0) begin
      it = random_req();
      if (n_rx == 0 || (n_tx > 0 && $urandom_range(1))) begin
        it.req_type = REQ_TX_EMPTY;
        n_tx--;
      end else begin
        it.req_type = REQ_RX_BYTE;
        n_rx--;
      end
      drive_request(it, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    out_item_t due;
    bit        moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        due = predict_lin_event(in_item);
        if (pin_valid) due = pin_event;
        lin_events_due.push_back(due);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (lin_events_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result: kind %0d tx %02h busy %0b",
                     out_item.event_kind, out_item.tx_byte, out_item.busy_res);
        end else begin
          due = lin_events_due.pop_front();
          case (due.event_kind)
            EV_ACCEPTED: sends_taken++;
            EV_BYTE_OUT: bytes_out++;
            EV_FRAME:    frames_seen++;
            default: ;
          endcase
          if (out_item.event_kind !== due.event_kind ||
              out_item.break_request !== due.break_request ||
              out_item.tx_byte !== due.tx_byte || out_item.rx_pid !== due.rx_pid ||
              out_item.rx_data !== due.rx_data || out_item.busy_res !== due.busy_res) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("mismatch (exp/got): kind %0d/%0d brk %0b/%0b tx %02h/%02h pid %02h/%02h",
                       due.event_kind, out_item.event_kind,
                       due.break_request, out_item.break_request,
                       due.tx_byte, out_item.tx_byte, due.rx_pid, out_item.rx_pid);
              $display("  data %016h/%016h busy %0b/%0b",
                       due.rx_data, out_item.rx_data, due.busy_res, out_item.busy_res);
            end
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int target;
    lin_script.push_back(lin_row(REQ_TX_EMPTY, 8'h00, 4'd0, '0, 0, 0, 8'h00, 1, 1,
                                 EV_TX_DONE, 0, 8'h00, 0));
    lin_script.push_back(lin_row(REQ_RX_BYTE, 8'h00, 4'd0, '0, 0, 0, 8'h00, 1, 1,
                                 EV_STORED, 0, 8'h00, 0));
    lin_script.push_back(lin_row(REQ_UNKNOWN, 8'hFF, 4'd15, '1, 1, 1, 8'hFF, 1, 1,
                                 EV_REJECTED, 0, 8'h00, 0));
    lin_script.push_back(lin_row(REQ_SEND, 8'h00, 4'd0, '0, 1, 1, 8'h00, 1, 1,
                                 EV_ACCEPTED, 1, 8'h00, 1));
    lin_script.push_back(lin_row(REQ_SEND, 8'hFF, 4'd15, '1, 1, 1, 8'hFF, 1, 1,
                                 EV_REJECTED, 0, 8'h00, 1));
    lin_script.push_back(lin_row(REQ_TX_EMPTY, 8'h00, 4'd0, '0, 0, 0, 8'h00, 1, 1,
                                 EV_BYTE_OUT, 0, SYNC_BYTE, 1));
    lin_script.push_back(lin_row(REQ_TX_EMPTY, 8'h00, 4'd0, '0, 0, 0, 8'h00, 1, 1,
                                 EV_BYTE_OUT, 0, 8'h00, 1));
    lin_script.push_back(lin_row(REQ_TX_EMPTY, 8'h00, 4'd0, '0, 0, 0, 8'h00, 1, 1,
                                 EV_TX_DONE, 0, 8'h00, 0));
    lin_script.push_back(lin_row(REQ_SEND, 8'hFF, 4'd8, '1, 0, 0, 8'h00, 1, 1,
                                 EV_ACCEPTED, 1, 8'h00, 1));
    lin_script.push_back(lin_row(REQ_RX_BYTE, 8'h00, 4'd0, '0, 0, 0, 8'hFF, 1, 1,
                                 EV_STORED, 0, 8'h00, 1));
    lin_script.push_back(lin_row(REQ_TX_EMPTY, 8'h00, 4'd0, '0, 0, 0, 8'h00, 1, 1,
                                 EV_BYTE_OUT, 0, SYNC_BYTE, 1));
    lin_script.push_back(lin_row(REQ_TX_EMPTY, 8'h00, 4'd0, '0, 0, 0, 8'h00, 1, 1,
                                 EV_BYTE_OUT, 0, 8'hFF, 1));
    lin_script.push_back(lin_row(REQ_TX_EMPTY, 8'h00, 4'd0, '0, 0, 0, 8'h00, 1, 1,
                                 EV_TX_DONE, 0, 8'h00, 0));
    lin_script.push_back(lin_row(REQ_SEND, 8'hFF, 4'd15, '1, 1, 1, 8'h00, 1, 1,
                                 EV_ACCEPTED, 1, 8'h00, 1));
    lin_script.push_back(lin_row(REQ_TX_EMPTY, 8'h00, 4'd0, '0, 0, 0, 8'h00, 2, 0,
                                 EV_BYTE_OUT, 0, 8'h00, 1));
    lin_script.push_back(lin_row(REQ_TX_EMPTY, 8'h00, 4'd0, '0, 0, 0, 8'h00, 8, 1,
                                 EV_BYTE_OUT, 0, 8'hFF, 1));
    lin_script.push_back(lin_row(REQ_TX_EMPTY, 8'h00, 4'd0, '0, 0, 0, 8'h00, 1, 1,
                                 EV_BYTE_OUT, 0, 8'h00, 1));
    lin_script.push_back(lin_row(REQ_TX_EMPTY, 8'h00, 4'd0, '0, 0, 0, 8'h00, 1, 1,
                                 EV_TX_DONE, 0, 8'h00, 0));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (lin_script[i])
      repeat (lin_script[i].reps) drive_request(lin_script[i].req, lin_script[i].pinned,
                                                lin_script[i].ev);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(99) < 80) begin
          run_frame_exchange();
        end else begin
          repeat ($urandom_range(4, 1)) drive_request(random_req(), 1'b0, '0);
        end
      end
    end
    in_valid <= 1'b0;

    while (lin_events_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d requests over four idling phases: %0d sends taken,", items_sent,
             sends_taken);
    $display("%0d bytes handed out, %0d frames received, %0d mismatches.", bytes_out,
             frames_seen, mismatches);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/lmfe_pkg.sv
sv/lmfe_ctrl.sv
sv/lmfe_datapath.sv
sv/lin_master_frame_engine.sv
tb/tb.sv
